/* sv/mtdq_pkg.sv */
// shared types and constants for the multi-target drop-oldest queue
// no dependencies
package mtdq_pkg;

    localparam int TARGETS_DEF      = 2;
    localparam int DEPTH_DEF        = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int TARGET_W = 2;
    localparam int DATA_W   = 32;
    localparam int FILL_W   = 7;

    typedef enum logic [2:0] {
        ST_PUSHED      = 3'd0,
        ST_PUSHED_DROP = 3'd1,
        ST_POPPED      = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_BAD_TARGET  = 3'd4
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [FILL_W-1:0]   fill;
        logic                mem_wr;
        logic                mem_rd;
    } t_op_res;

endpackage

/* sv/mtdq_ram.sv */
// shared entry store: single-port synchronous memory with a registered read
// depends on nothing but its parameters
module mtdq_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_wr,
    input  logic                 i_rd,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [DATA_BITS-1:0] i_wdata,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_W];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mtdq_ptr.sv */
// per-target head and count registers with the push/pop pointer update
// depends on mtdq_pkg
module mtdq_ptr
    import mtdq_pkg::*;
#(
    parameter int TARGETS = TARGETS_DEF,
    parameter int DEPTH = DEPTH_DEF,
    parameter int ADDR_W = $clog2(TARGETS * DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_op,
    input  logic [TARGET_W-1:0] i_target,
    output t_op_res             o_res,
    output logic [ADDR_W-1:0]   o_addr
);

    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = HW + 1;
    localparam int TW = (TARGETS > 1) ? $clog2(TARGETS) : 1;

    logic [HW-1:0] r_head [TARGETS];
    logic [CW-1:0] r_cnt  [TARGETS];

    logic [HW-1:0] n_head;
    logic [CW-1:0] n_cnt;
    logic          upd;
    logic [TW-1:0] tidx;

    assign tidx = TW'(i_target);

    always_comb begin
        logic          bad;
        logic [HW-1:0] head;
        logic [HW-1:0] head_inc;
        logic [CW-1:0] cnt;
        logic [CW-1:0] base_cnt;
        logic [SW-1:0] sum;
        logic [HW-1:0] slot;

        bad      = ({1'b0, i_target} >= (TARGET_W + 1)'(TARGETS));
        head     = r_head[tidx];
        cnt      = r_cnt[tidx];
        head_inc = (head == HW'(DEPTH - 1)) ? '0 : head + HW'(1);

        n_head   = head;
        n_cnt    = cnt;
        upd      = 1'b0;
        base_cnt = cnt;
        sum      = '0;
        slot     = head;
        o_res    = '{status: ST_BAD_TARGET, fill: '0, mem_wr: 1'b0, mem_rd: 1'b0};

        if (!bad) begin
            if (!i_op) begin
                if (cnt == CW'(DEPTH)) begin
                    n_head       = head_inc;
                    base_cnt     = CW'(DEPTH - 1);
                    o_res.status = ST_PUSHED_DROP;
                end else begin
                    o_res.status = ST_PUSHED;
                end
                sum = SW'(n_head) + SW'(base_cnt);
                if (sum >= SW'(DEPTH)) begin
                    sum = sum - SW'(DEPTH);
                end
                slot         = sum[HW-1:0];
                n_cnt        = base_cnt + CW'(1);
                upd          = 1'b1;
                o_res.mem_wr = 1'b1;
                o_res.fill   = FILL_W'(n_cnt);
            end else if (cnt == '0) begin
                o_res.status = ST_EMPTY;
            end else begin
                n_head       = head_inc;
                n_cnt        = cnt - CW'(1);
                upd          = 1'b1;
                o_res.mem_rd = 1'b1;
                o_res.status = ST_POPPED;
                o_res.fill   = FILL_W'(n_cnt);
            end
        end

        o_addr = ADDR_W'(tidx) * ADDR_W'(DEPTH) + ADDR_W'(slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TARGETS; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (i_en && upd) begin
            r_head[tidx] <= n_head;
            r_cnt[tidx]  <= n_cnt;
        end
    end

endmodule

/* sv/multi_target_drop_oldest_queue_unit.sv */
// top level of the multi-target drop-oldest queue
// depends on mtdq_pkg, mtdq_ptr and mtdq_ram
//
// usage:
//   input channel (i_valid / o_stall) carries one transaction per item:
//   i_op 0 pushes i_payload into queue i_target, i_op 1 pops its head.
//   a push into a full queue drops the oldest entry first.
//   output channel (o_valid / i_stall) returns one result per transaction:
//   o_status, o_data_out (popped word, else zero) and o_fill_level.
//   the result is presented the cycle after the transaction is accepted;
//   throughput is one transaction per cycle unless stalled, set by the single
//   port of the entry store (one write or one read per transaction).
//   head and count for each queue are updated at the accepting edge, so
//   consecutive transactions to the same queue need no extra wait.
//   reset clears every queue to empty and drops any pending result; the
//   entry store itself is not cleared.
//   while the receiver stalls, the result is held and o_stall rises, so
//   at most one result is ever waiting.
module multi_target_drop_oldest_queue_unit
    import mtdq_pkg::*;
#(
    parameter int TARGETS = TARGETS_DEF,
    parameter int DEPTH = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [TARGET_W-1:0] i_target,
    input  logic [DATA_W-1:0]   i_payload,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [DATA_W-1:0]   o_data_out,
    output logic [FILL_W-1:0]   o_fill_level
);

    localparam int ADDR_W = $clog2(TARGETS * DEPTH);

    t_op_res                 res;
    logic [ADDR_W-1:0]       addr;
    logic [PAYLOAD_BITS-1:0] rdata;
    logic                    accept;

    logic                    r_valid;
    t_status                 r_status;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_pop;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    mtdq_ptr #(
        .TARGETS (TARGETS),
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_ptr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_op     (i_op),
        .i_target (i_target),
        .o_res    (res),
        .o_addr   (addr)
    );

    mtdq_ram #(
        .ADDR_W    (ADDR_W),
        .DATA_BITS (PAYLOAD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr    (accept && res.mem_wr),
        .i_rd    (accept && res.mem_rd),
        .i_addr  (addr),
        .i_wdata (PAYLOAD_BITS'(i_payload)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid  <= 1'b1;
            r_status <= res.status;
            r_fill   <= res.fill;
            r_pop    <= res.mem_rd;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_fill_level = r_fill;
    assign o_data_out   = r_pop ? DATA_W'(rdata) : '0;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted transaction produced no result");

    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.mem_wr && res.mem_rd))
        else $error("store written and read by one transaction");

    a_data_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_POPPED)) |-> (o_data_out == '0))
        else $error("nonzero data on a result that is not a pop");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == ST_EMPTY) || (o_status == ST_BAD_TARGET)))
            |-> (o_fill_level == '0))
        else $error("nonzero fill level on empty or rejected transaction");

endmodule
